// File: hdl/ctw_pkg.sv
// shared types, widths, register map and reset values for the cubic table waveshaper
// no dependencies
`default_nettype none

package ctw_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int DRIVE_W        = 16;
    localparam int OUT_GAIN_W     = 20;
    localparam int RAMP_CFG_W     = 13;
    localparam int SCALE_W        = 16;
    localparam int GAIN_DIFF_W    = OUT_GAIN_W + 1;
    localparam int FRAC_W         = 16;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    localparam int TABLE_DEPTH_DEF = 4097;
    localparam int MAX_RAMP_DEF    = 4096;

    localparam logic [DRIVE_W-1:0]    DRIVE_RST    = DRIVE_W'(16384);
    localparam logic [OUT_GAIN_W-1:0] OUT_GAIN_RST = OUT_GAIN_W'(65536);
    localparam logic [RAMP_CFG_W-1:0] RAMP_LEN_RST = RAMP_CFG_W'(64);
    localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(43691);

    // register index codes
    localparam logic [2:0] REG_BYPASS      = 3'd0;
    localparam logic [2:0] REG_DRIVE_GAIN  = 3'd1;
    localparam logic [2:0] REG_OUTPUT_GAIN = 3'd2;
    localparam logic [2:0] REG_RAMP_LENGTH = 3'd3;
    localparam logic [2:0] REG_INDEX_SCALE = 3'd4;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic [DRIVE_W-1:0]    drive;
        logic [OUT_GAIN_W-1:0] out_gain;
    } t_gains;

    typedef logic signed [SAMPLE_W-1:0] t_pts [4];

endpackage

`default_nettype wire

// File: hdl/ctw_table_ram.sv
// transfer curve memory: one write port, one registered read port
// depends on ctw_pkg
`default_nettype none

module ctw_table_ram
    import ctw_pkg::*;
#(
    parameter int DEPTH  = TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire  [ADDR_W-1:0]   i_waddr,
    input  wire  [SAMPLE_W-1:0] i_wdata,
    input  wire  [ADDR_W-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/ctw_gain_ramp.sv
// gain glide: holds the gains in use and steps them toward the targets,
// one serial restoring divide per gain; depends on ctw_pkg
`default_nettype none

module ctw_gain_ramp
    import ctw_pkg::*;
#(
    parameter int MAX_RAMP = MAX_RAMP_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_restart,
    input  wire  [DRIVE_W-1:0]    i_drive_tgt,
    input  wire  [OUT_GAIN_W-1:0] i_output_tgt,
    input  wire  [RAMP_CFG_W-1:0] i_ramp_len,
    input  wire                   i_start,
    output logic                  o_done,
    output t_gains                o_gains
);

    localparam int RLW = $clog2(MAX_RAMP + 1);
    localparam int LW  = (RLW > RAMP_CFG_W) ? RLW : RAMP_CFG_W;
    localparam int DW  = GAIN_DIFF_W + RLW;
    localparam int CW  = $clog2(DW + 1);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_MUL  = 2'd1;
    localparam logic [1:0] R_DIV  = 2'd2;
    localparam logic [1:0] R_UPD  = 2'd3;

    logic [1:0]     r_state;
    t_gains         r_cur;
    t_gains         r_start;
    logic [RLW-1:0] r_pos;
    logic           r_sel;
    logic           r_neg;
    logic [DW-1:0]  r_quo;
    logic [LW-1:0]  r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_done;

    logic [LW-1:0]                 len_ext;
    logic [LW-1:0]                 eff_len;
    logic signed [GAIN_DIFF_W-1:0] start_s;
    logic signed [GAIN_DIFF_W-1:0] tgt_s;
    logic signed [GAIN_DIFF_W-1:0] diff;
    logic signed [DW:0]            prod;
    logic [LW:0]                   rem_sh;
    logic signed [GAIN_DIFF_W-1:0] q_s;
    logic signed [GAIN_DIFF_W-1:0] new_gain;

    always_comb begin
        len_ext = LW'(i_ramp_len);
        if (len_ext == '0) begin
            eff_len = LW'(1);
        end else if (len_ext > LW'(MAX_RAMP)) begin
            eff_len = LW'(MAX_RAMP);
        end else begin
            eff_len = len_ext;
        end
        if (r_sel) begin
            start_s = $signed({1'b0, r_start.out_gain});
            tgt_s   = $signed({1'b0, i_output_tgt});
        end else begin
            start_s = $signed(GAIN_DIFF_W'({1'b0, r_start.drive}));
            tgt_s   = $signed(GAIN_DIFF_W'({1'b0, i_drive_tgt}));
        end
        diff     = tgt_s - start_s;
        prod     = (DW+1)'(diff) * $signed((DW+1)'({1'b0, r_pos}));
        rem_sh   = {r_rem, r_quo[DW-1]};
        q_s      = r_neg ? -$signed({1'b0, r_quo[GAIN_DIFF_W-2:0]})
                         :  $signed({1'b0, r_quo[GAIN_DIFF_W-2:0]});
        new_gain = start_s + q_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_cur   <= '{drive: DRIVE_RST, out_gain: OUT_GAIN_RST};
            r_start <= '0;
            r_pos   <= '0;
            r_sel   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                R_IDLE: begin
                    if (i_restart) begin
                        r_start <= r_cur;
                        r_pos   <= RLW'(1);
                    end else if (i_start) begin
                        if (r_pos == '0) begin
                            r_done <= 1'b1;
                        end else if (LW'(r_pos) >= eff_len) begin
                            r_cur  <= '{drive: i_drive_tgt, out_gain: i_output_tgt};
                            r_pos  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_sel   <= 1'b0;
                            r_state <= R_MUL;
                        end
                    end
                end
                R_MUL: begin
                    r_neg   <= prod < 0;
                    r_quo   <= (prod < 0) ? DW'(-prod) : DW'(prod);
                    r_rem   <= '0;
                    r_cnt   <= CW'(DW);
                    r_state <= R_DIV;
                end
                R_DIV: begin
                    if (rem_sh >= {1'b0, eff_len}) begin
                        r_rem <= LW'(rem_sh - {1'b0, eff_len});
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= LW'(rem_sh);
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= R_UPD;
                    end
                end
                R_UPD: begin
                    if (r_sel) begin
                        r_cur.out_gain <= OUT_GAIN_W'(new_gain);
                        r_pos          <= r_pos + RLW'(1);
                        r_done         <= 1'b1;
                        r_state        <= R_IDLE;
                    end else begin
                        r_cur.drive <= DRIVE_W'(new_gain);
                        r_sel       <= 1'b1;
                        r_state     <= R_MUL;
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_gains = r_cur;

endmodule

`default_nettype wire

// File: hdl/ctw_interp.sv
// catmull-rom evaluation by horner steps, output gain, rounding and saturation
// seven registered stages; depends on ctw_pkg
`default_nettype none

module ctw_interp
    import ctw_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  t_pts                  i_pts,
    input  wire  [FRAC_W:0]       i_t,
    input  wire  [OUT_GAIN_W-1:0] i_out_gain,
    output logic                  o_done,
    output logic [SAMPLE_W-1:0]   o_sample
);

    localparam int CW  = SAMPLE_W + 4;
    localparam int TW  = FRAC_W + 2;
    localparam int H1W = CW + TW;
    localparam int P2W = H1W + TW;
    localparam int H2W = P2W - FRAC_W;
    localparam int H3W = H2W + TW;
    localparam int YW  = H3W - 33;
    localparam int MW  = YW + OUT_GAIN_W + 1;
    localparam int RW  = MW - 8;

    logic [6:0] r_vld;

    logic signed [CW-1:0]  r_c0, r_c1, r_c2, r_c3;
    logic signed [H1W-1:0] r_h1;
    logic signed [H2W-1:0] r_h2;
    logic signed [H3W-1:0] r_h3;
    logic signed [YW-1:0]  r_y;
    logic signed [MW-1:0]  r_m;
    logic [SAMPLE_W-1:0]   r_out;

    logic signed [CW-1:0]  e0, e1, e2, e3;
    logic signed [TW-1:0]  t_s;
    logic signed [P2W-1:0] p2;
    logic signed [H3W-1:0] h3_rnd;
    logic signed [RW-1:0]  rnd;

    always_comb begin
        e0     = CW'(i_pts[0]);
        e1     = CW'(i_pts[1]);
        e2     = CW'(i_pts[2]);
        e3     = CW'(i_pts[3]);
        t_s    = $signed({1'b0, i_t});
        p2     = P2W'(r_h1) * P2W'(t_s) + (P2W'(r_c2) <<< 32);
        h3_rnd = r_h3 + (H3W'(1) <<< 32);
        rnd    = RW'((r_m + MW'(256)) >>> 9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0 <= -e0 + 3 * e1 - 3 * e2 + e3;
        r_c1 <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
        r_c2 <= e2 - e0;
        r_c3 <= 2 * e1;
        r_h1 <= H1W'(r_c0) * H1W'(t_s) + (H1W'(r_c1) <<< FRAC_W);
        r_h2 <= H2W'(p2 >>> FRAC_W);
        r_h3 <= H3W'(r_h2) * H3W'(t_s) + (H3W'(r_c3) <<< 32);
        r_y  <= YW'(h3_rnd >>> 33);
        r_m  <= MW'(r_y) * $signed(MW'({1'b0, i_out_gain}));
        if (rnd > RW'(8388607)) begin
            r_out <= 24'h7FFFFF;
        end else if (rnd < -RW'(8388608)) begin
            r_out <= 24'h800000;
        end else begin
            r_out <= SAMPLE_W'(rnd);
        end
    end

    assign o_done   = r_vld[6];
    assign o_sample = r_out;

endmodule

`default_nettype wire

// File: hdl/cubic_table_waveshaper_unit.sv
// a table load writes the memory directly; a bypass sample goes via ST_OUT to the output
// register; a processed sample runs ST_GAIN, ST_MUL1, ST_MUL2, ST_POS, ST_READ, ST_INTERP,
// ST_OUT; ST_GAIN holds on a glide step for two serial divides of 34 quotient bits each;
// one transaction at a time; one table load per cycle while no sample is in flight;
// four reads on the one table read port and the seven-stage interpolation pace each sample
// reset: synchronous active low, registers and gains to defaults; table contents undefined
`default_nettype none

module cubic_table_waveshaper_unit
    import ctw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_RAMP    = MAX_RAMP_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input channel
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_command,
    input  wire  [ADDR_W-1:0]     i_table_address,
    input  wire  [SAMPLE_W-1:0]   i_table_value,
    input  wire  [SAMPLE_W-1:0]   i_sample_in,
    // output channel
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [SAMPLE_W-1:0]   o_sample_out,
    // configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_AW-1:0]     paddr,
    input  wire  [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int LAST   = TABLE_DEPTH - 1;
    localparam int CENTRE = (TABLE_DEPTH - 1) / 2;
    localparam int P1W    = SAMPLE_W + DRIVE_W + 1;
    localparam int P2W    = P1W + SCALE_W + 1;
    localparam int PW     = ADDR_W + FRAC_W + 14;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GAIN   = 3'd1;
    localparam logic [2:0] ST_MUL1   = 3'd2;
    localparam logic [2:0] ST_MUL2   = 3'd3;
    localparam logic [2:0] ST_POS    = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_INTERP = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // configuration registers
    logic                  r_bypass;
    logic [DRIVE_W-1:0]    r_drive_tgt;
    logic [OUT_GAIN_W-1:0] r_output_tgt;
    logic [RAMP_CFG_W-1:0] r_ramp_len;
    logic [SCALE_W-1:0]    r_scale;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       gain_wr;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];
    assign gain_wr = cfg_wr & ((cfg_idx == REG_DRIVE_GAIN) | (cfg_idx == REG_OUTPUT_GAIN));
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass     <= 1'b0;
            r_drive_tgt  <= DRIVE_RST;
            r_output_tgt <= OUT_GAIN_RST;
            r_ramp_len   <= RAMP_LEN_RST;
            r_scale      <= SCALE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BYPASS:      r_bypass     <= pwdata[0];
                REG_DRIVE_GAIN:  r_drive_tgt  <= pwdata[DRIVE_W-1:0];
                REG_OUTPUT_GAIN: r_output_tgt <= pwdata[OUT_GAIN_W-1:0];
                REG_RAMP_LENGTH: r_ramp_len   <= pwdata[RAMP_CFG_W-1:0];
                REG_INDEX_SCALE: r_scale      <= pwdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_BYPASS:      prdata = APB_DW'(r_bypass);
            REG_DRIVE_GAIN:  prdata = APB_DW'(r_drive_tgt);
            REG_OUTPUT_GAIN: prdata = APB_DW'(r_output_tgt);
            REG_RAMP_LENGTH: prdata = APB_DW'(r_ramp_len);
            REG_INDEX_SCALE: prdata = APB_DW'(r_scale);
            default:         prdata = '0;
        endcase
    end

    // sequencer and datapath registers
    logic [2:0]                r_state;
    logic                      r_ramp_go;
    logic                      r_interp_go;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [P1W-1:0]     r_p1;
    logic signed [P2W-1:0]     r_p2;
    logic [ADDR_W-1:0]         r_i1;
    logic [FRAC_W:0]           r_t;
    logic [2:0]                r_rd_cnt;
    t_pts                      r_pts;
    logic [SAMPLE_W-1:0]       r_result;
    logic                      r_out_valid;
    logic [SAMPLE_W-1:0]       r_sample_out;

    logic                in_accept;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                ramp_done;
    t_gains              gains;
    logic                interp_done;
    logic [SAMPLE_W-1:0] interp_sample;

    logic signed [PW-1:0] pos;
    logic signed [PW-1:0] pos_cl;
    logic [ADDR_W-1:0]    i1_n;
    logic [FRAC_W:0]      t_n;
    logic [ADDR_W-1:0]    idx0, idx2, idx3;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid & ~o_in_stall;
    // table loads go straight to the memory; out of range addresses are dropped
    assign ram_we     = in_accept & (i_command == CMD_LOAD)
                        & ({1'b0, i_table_address} < (ADDR_W+1)'(TABLE_DEPTH));

    // clamp the fractional position and split it into entry and fraction
    always_comb begin
        pos = PW'(r_p2 >>> 29) + (PW'(CENTRE) <<< FRAC_W);
        if (pos < 0) begin
            pos_cl = '0;
        end else if (pos > (PW'(LAST) <<< FRAC_W)) begin
            pos_cl = PW'(LAST) <<< FRAC_W;
        end else begin
            pos_cl = pos;
        end
        if (pos_cl[PW-1:FRAC_W] >= (PW-FRAC_W)'(LAST)) begin
            // right edge: use the last span with the fraction at one
            i1_n = ADDR_W'(LAST - 1);
            t_n  = (FRAC_W+1)'(1) << FRAC_W;
        end else begin
            i1_n = pos_cl[ADDR_W+FRAC_W-1:FRAC_W];
            t_n  = {1'b0, pos_cl[FRAC_W-1:0]};
        end
    end

    // neighbor entries, clamped at both edges
    always_comb begin
        idx0 = (r_i1 == '0) ? '0 : r_i1 - ADDR_W'(1);
        idx2 = r_i1 + ADDR_W'(1);
        idx3 = (r_i1 == ADDR_W'(LAST - 1)) ? ADDR_W'(LAST) : r_i1 + ADDR_W'(2);
        case (r_rd_cnt)
            3'd0:    ram_raddr = idx0;
            3'd1:    ram_raddr = r_i1;
            3'd2:    ram_raddr = idx2;
            default: ram_raddr = idx3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ramp_go   <= 1'b0;
            r_interp_go <= 1'b0;
            r_rd_cnt    <= '0;
        end else begin
            r_ramp_go   <= 1'b0;
            r_interp_go <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_accept && (i_command == CMD_SAMPLE)) begin
                        if (r_bypass) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_ramp_go <= 1'b1;
                            r_state   <= ST_GAIN;
                        end
                    end
                end
                ST_GAIN: begin
                    if (ramp_done) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_state <= ST_POS;
                end
                ST_POS: begin
                    r_rd_cnt <= '0;
                    r_state  <= ST_READ;
                end
                ST_READ: begin
                    // one address per cycle, its data lands in the next cycle
                    r_rd_cnt <= r_rd_cnt + 3'd1;
                    if (r_rd_cnt == 3'd4) begin
                        r_interp_go <= 1'b1;
                        r_state     <= ST_INTERP;
                    end
                end
                ST_INTERP: begin
                    if (interp_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x      <= $signed(i_sample_in);
            r_result <= i_sample_in;
        end
        if (r_state == ST_MUL1) begin
            r_p1 <= P1W'(r_x) * $signed(P1W'({1'b0, gains.drive}));
        end
        if (r_state == ST_MUL2) begin
            r_p2 <= P2W'(r_p1) * $signed(P2W'({1'b0, r_scale}));
        end
        if (r_state == ST_POS) begin
            r_i1 <= i1_n;
            r_t  <= t_n;
        end
        if ((r_state == ST_READ) && (r_rd_cnt != 3'd0)) begin
            r_pts[r_rd_cnt[1:0] - 2'd1] <= $signed(ram_rdata);
        end
        if ((r_state == ST_INTERP) && interp_done) begin
            r_result <= interp_sample;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_sample_out <= r_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    ctw_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_table_address),
        .i_wdata (i_table_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ctw_gain_ramp #(
        .MAX_RAMP (MAX_RAMP)
    ) u_ramp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (gain_wr),
        .i_drive_tgt  (r_drive_tgt),
        .i_output_tgt (r_output_tgt),
        .i_ramp_len   (r_ramp_len),
        .i_start      (r_ramp_go),
        .o_done       (ramp_done),
        .o_gains      (gains)
    );

    ctw_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_interp_go),
        .i_pts      (r_pts),
        .i_t        (r_t),
        .i_out_gain (gains.out_gain),
        .o_done     (interp_done),
        .o_sample   (interp_sample)
    );

endmodule

`default_nettype wire

// File: hdl/ctw_checker.sv
// port-level checks on the waveshaper, bound to the top level
// depends on ctw_pkg and cubic_table_waveshaper_unit
`default_nettype none

module ctw_checker
    import ctw_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire                  i_command,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire [SAMPLE_W-1:0]   o_sample_out
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled result changed");

    // a table load makes no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_LOAD) && !o_out_valid
        |=> !o_out_valid)
        else $error("result after table load");

    // a sample transaction occupies the block
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_SAMPLE) |=> o_in_stall)
        else $error("sample did not occupy the block");

endmodule

bind cubic_table_waveshaper_unit ctw_checker u_ctw_checker (.*);

`default_nettype wire
